// ===== hdl/crpq_pkg.sv =====
`timescale 1ns / 1ps

package crpq_pkg;

   localparam int ADDR_IN_W = 32;
   localparam int GEN_W     = 32;
   localparam int CLIP_W    = 8;
   localparam int VADDR_W   = 32;
   localparam int PAGE_OUT_W = 12;
   localparam int STATUS_W  = 3;

   // payload: alloc_gen, content_gen, clipmap_index, virtual_address, residency_gen
   localparam int PAYLOAD_W = GEN_W + GEN_W + CLIP_W + VADDR_W + GEN_W;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 152;

   localparam logic [STATUS_W-1:0] STATUS_NEW    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MERGED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TAKEN  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd4;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_TAKE   = 1'b1;

   localparam logic [1:0] KIND_STALE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_RECORD = 2'd2;
   localparam logic [1:0] KIND_TAKEN  = 2'd3;

   typedef struct packed {
      logic       clear_wr;
      logic       capture;
      logic       mark_rd;
      logic       order_rd;
      logic       rec_upd;
      logic       take_pop;
      logic       rsp_load;
      logic [1:0] rsp_kind;
   } crpq_cmd_type;

   typedef struct packed {
      logic is_take;
      logic is_stale;
      logic empty;
      logic clear_last;
   } crpq_sts_type;

endpackage

// ===== hdl/crpq_ctrl.sv =====
`timescale 1ns / 1ps

module crpq_ctrl import crpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  crpq_sts_type sts,
   output crpq_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DECODE   = 3'd2;
   localparam logic [2:0] ST_REC_UPD  = 3'd3;
   localparam logic [2:0] ST_TAKE_IDX = 3'd4;
   localparam logic [2:0] ST_TAKE_OUT = 3'd5;
   localparam logic [2:0] ST_RESP     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_take) begin
               if (sts.empty) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = KIND_EMPTY;
                  state_in     = ST_RESP;
               end else begin
                  cmd.order_rd = 1'b1;
                  state_in     = ST_TAKE_IDX;
               end
            end else if (sts.is_stale) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = KIND_STALE;
               state_in     = ST_RESP;
            end else begin
               cmd.mark_rd = 1'b1;
               state_in    = ST_REC_UPD;
            end
         end
         ST_REC_UPD: begin
            cmd.rec_upd  = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = KIND_RECORD;
            state_in     = ST_RESP;
         end
         ST_TAKE_IDX: begin
            cmd.take_pop = 1'b1;
            state_in     = ST_TAKE_OUT;
         end
         ST_TAKE_OUT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = KIND_TAKEN;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== hdl/crpq_datapath.sv =====
`timescale 1ns / 1ps

module crpq_datapath import crpq_pkg::*; #(
   parameter int PAGES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  crpq_cmd_type            cmd,
   output crpq_sts_type            sts,
   input  logic                    req_type,
   input  logic [ADDR_IN_W-1:0]    req_page,
   input  logic [PAYLOAD_W-1:0]    req_payload,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [PAGE_OUT_W-1:0]   rsp_page,
   output logic [PAYLOAD_W-1:0]    rsp_payload,
   output logic                    rsp_last
);

   localparam int IDX_W = $clog2(PAGES);
   localparam int CNT_W = $clog2(PAGES + 1);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(PAGES - 1);
   localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(PAGES);
   localparam logic [ADDR_IN_W:0] PAGE_LIMIT = (ADDR_IN_W + 1)'(PAGES);

   logic                    mark_mem  [PAGES];
   logic [IDX_W-1:0]        order_mem [PAGES];
   logic [PAYLOAD_W-1:0]    pay_mem   [PAGES];

   logic                    req_type_ff;
   logic [ADDR_IN_W-1:0]    req_page_ff;
   logic [PAYLOAD_W-1:0]    req_payload_ff;

   logic                    mark_rd_ff;
   logic [IDX_W-1:0]        order_rd_ff;
   logic [PAYLOAD_W-1:0]    pay_rd_ff;

   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;

   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [PAGE_OUT_W-1:0]   rsp_page_ff;
   logic [PAYLOAD_W-1:0]    rsp_payload_ff;
   logic                    rsp_last_ff;

   logic [IDX_W-1:0]        idx;
   logic                    push;
   logic [31:0]             take_idx_wide;

   assign idx  = req_page_ff[IDX_W-1:0];
   assign push = cmd.rec_upd && !mark_rd_ff && (count_ff < FULL_COUNT);
   assign take_idx_wide = 32'(order_rd_ff);

   assign sts.is_take    = (req_type_ff == REQ_TAKE);
   assign sts.is_stale   = ({1'b0, req_page_ff} >= PAGE_LIMIT);
   assign sts.empty      = (count_ff == '0);
   assign sts.clear_last = (clr_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff    <= req_type;
         req_page_ff    <= req_page;
         req_payload_ff <= req_payload;
      end
   end

   // mark store, cleared by a sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mark_mem[clr_ff] <= 1'b0;
      end else if (cmd.rec_upd) begin
         mark_mem[idx] <= 1'b1;
      end else if (cmd.take_pop) begin
         mark_mem[order_rd_ff] <= 1'b0;
      end
      if (cmd.mark_rd) begin
         mark_rd_ff <= mark_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         order_mem[tail_ff] <= idx;
      end
      if (cmd.order_rd) begin
         order_rd_ff <= order_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rec_upd) begin
         pay_mem[idx] <= req_payload_ff;
      end
      if (cmd.take_pop) begin
         pay_rd_ff <= pay_mem[order_rd_ff];
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      clr_in   = clr_ff;
      if (cmd.clear_wr && (clr_ff != LAST_IDX)) begin
         clr_in = clr_ff + 1'b1;
      end
      if (push) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (cmd.take_pop) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_page_ff    <= '0;
         rsp_payload_ff <= '0;
         rsp_last_ff    <= 1'b0;
         case (cmd.rsp_kind)
            KIND_STALE: begin
               rsp_status_ff <= STATUS_STALE;
            end
            KIND_EMPTY: begin
               rsp_status_ff <= STATUS_EMPTY;
            end
            KIND_RECORD: begin
               rsp_status_ff <= mark_rd_ff ? STATUS_MERGED : STATUS_NEW;
            end
            KIND_TAKEN: begin
               rsp_status_ff  <= STATUS_TAKEN;
               rsp_page_ff    <= take_idx_wide[PAGE_OUT_W-1:0];
               rsp_payload_ff <= pay_rd_ff;
               rsp_last_ff    <= (count_ff == '0);
            end
            default: begin
               rsp_status_ff <= STATUS_STALE;
            end
         endcase
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_page    = rsp_page_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== hdl/coalescing_ready_page_queue.sv =====
`timescale 1ns / 1ps

// Coalescing ready-page queue.
// req channel: tuser = req_type (0 record page, 1 take oldest page). A record
//   item carries page index and payload in tdata; a take item ignores tdata.
// rsp channel: exactly one item per request. tuser = status (new, merged,
//   stale, taken, empty), tlast = the take left the queue empty, tdata =
//   page index and payload of a taken entry, zero for every other status.
// One request is in flight at a time. A stale record or a take while empty
//   goes from decode straight to the response; a record passes through the
//   record update state and a take through the take index and take out
//   states, for the registered reads of the mark, order and payload
//   memories. req_tready rises at the edge that takes the rsp item, so a new
//   request is accepted only after the previous rsp item is taken.
// Reset: head, tail and count clear at once; then the mark memory is swept,
//   one entry a cycle over all PAGES entries, with req_tready held low.
// A stalled rsp item holds its value with rsp_tvalid high until rsp_tready;
//   req_tready stays low meanwhile.
module coalescing_ready_page_queue import crpq_pkg::*; #(
   parameter int PAGES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // page_index, alloc_gen, content_gen,
                                             // clipmap_index, virtual_address,
                                             // residency_gen
   input  logic                  req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_page, out_alloc_gen, out_content_gen,
                                             // out_clipmap, out_vaddr,
                                             // out_residency_gen, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser,  // status
   output logic                  rsp_tlast   // last
);

   crpq_cmd_type            cmd;
   crpq_sts_type            sts;
   logic [PAGE_OUT_W-1:0]   rsp_page;
   logic [PAYLOAD_W-1:0]    rsp_payload;

   crpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   crpq_datapath #(
      .PAGES (PAGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_type    (req_tuser),
      .req_page    (req_tdata[ADDR_IN_W-1:0]),
      .req_payload (req_tdata[ADDR_IN_W +: PAYLOAD_W]),
      .rsp_status  (rsp_tuser),
      .rsp_page    (rsp_page),
      .rsp_payload (rsp_payload),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - PAGE_OUT_W - PAYLOAD_W)'(0), rsp_payload, rsp_page};

endmodule
